[hw/rtl/coverage_index_lookup_top_defines.svh]
// ----------------------------------------------------------------------------
// Coverage index lookup: assertion macros
// Shared helpers for the concurrent checks of the lookup block.
// ----------------------------------------------------------------------------
`ifndef COVERAGE_INDEX_LOOKUP_TOP_DEFINES_SVH
`define COVERAGE_INDEX_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, cleared during reset.
`define CIL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("coverage lookup check failed");

// Next-cycle implication, cleared during reset.
`define CIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("coverage lookup check failed");

`endif

[hw/rtl/cil_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage index lookup package
// Widths, codes and shared types of the coverage table lookup block.
// ----------------------------------------------------------------------------
package cil_pkg;

	localparam int MaxEntries  = 1024;
	localparam int AddrWidth   = $clog2(MaxEntries);
	localparam int CountWidth  = AddrWidth + 1;
	localparam int GlyphWidth  = 16;
	localparam int IndexWidth  = GlyphWidth + 1;
	localparam int FormatWidth = 2;
	localparam int CfgIdxWidth = 1;
	localparam int CfgDataWidth = CountWidth;

	// request operations
	localparam logic OpLoad   = 1'b0;
	localparam logic OpLookup = 1'b1;

	// table formats
	localparam logic [FormatWidth-1:0] FmtList  = 2'd1;
	localparam logic [FormatWidth-1:0] FmtRange = 2'd2;

	// register indexes
	localparam logic [CfgIdxWidth-1:0] CfgTableFormat = 1'b0;
	localparam logic [CfgIdxWidth-1:0] CfgEntryCount  = 1'b1;

	typedef struct packed {
		logic [GlyphWidth-1:0] first;
		logic [GlyphWidth-1:0] last;
		logic [GlyphWidth-1:0] start;
	} entry_t;

	localparam int EntryWidth = $bits(entry_t);

	typedef struct packed {
		logic                  found;
		logic [IndexWidth-1:0] index;
	} result_t;

	typedef struct packed {
		logic    idle;
		logic    hold_valid;
		result_t result;
	} srch_status_t;

endpackage

[hw/rtl/coverage_index_lookup_top.sv]
`timescale 1ns / 1ps
// A load request writes its entry into the table RAM when accepted and gives no result.
// A lookup makes p table probes, one per cycle through the RAM read port,
// p <= 11 for a full table; the result then waits for the output register.
// Requests are taken only while idle: one load per cycle while no lookup is busy.
// Reset: table_format = 1, entry_count = 0; table RAM is not cleared.
// ----------------------------------------------------------------------------
// Coverage index lookup top level
// Holds a coverage table in RAM and answers glyph lookups by binary search.
// ----------------------------------------------------------------------------
`include "coverage_index_lookup_top_defines.svh"

module coverage_index_lookup_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_enable,
	input  logic [cil_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  logic [cil_pkg::CfgDataWidth-1:0]    cfg_data,
	input  logic                                request_valid,
	output logic                                request_ready,
	input  logic                                operation,
	input  logic [cil_pkg::AddrWidth-1:0]       entry_index,
	input  logic [cil_pkg::GlyphWidth-1:0]      first_glyph,
	input  logic [cil_pkg::GlyphWidth-1:0]      last_glyph,
	input  logic [cil_pkg::GlyphWidth-1:0]      start_index,
	input  logic [cil_pkg::GlyphWidth-1:0]      glyph_id,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                found,
	output logic [cil_pkg::IndexWidth-1:0]      coverage_index
);

	logic [cil_pkg::FormatWidth-1:0] format_q;
	logic [cil_pkg::CountWidth-1:0]  count_q;

	logic                           req_accept;
	logic                           load_en;
	logic                           lookup_start;
	logic                           take;
	logic [cil_pkg::AddrWidth-1:0]  rd_addr;
	cil_pkg::entry_t                wr_entry;
	cil_pkg::entry_t                rd_entry;
	cil_pkg::srch_status_t          srch_status;

	logic                           result_valid_q;
	logic                           found_q;
	logic [cil_pkg::IndexWidth-1:0] index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= cil_pkg::FmtList;
			count_q  <= '0;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				cil_pkg::CfgTableFormat: format_q <= cfg_data[cil_pkg::FormatWidth-1:0];
				cil_pkg::CfgEntryCount:  count_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign request_ready = srch_status.idle;
	assign req_accept    = request_valid && request_ready;
	assign load_en       = req_accept && (operation == cil_pkg::OpLoad);
	assign lookup_start  = req_accept && (operation == cil_pkg::OpLookup);
	assign wr_entry      = '{first: first_glyph, last: last_glyph, start: start_index};

	// hand the held result over once the output register is free
	assign take = srch_status.hold_valid && (!result_valid_q || result_ready);

	cil_table_ram #(
		.DEPTH(cil_pkg::MaxEntries),
		.WIDTH(cil_pkg::EntryWidth)
	) u_ram (
		.clk     (clk),
		.wr_en   (load_en),
		.wr_addr (entry_index),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	cil_search u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (lookup_start),
		.glyph_id     (glyph_id),
		.table_format (format_q),
		.entry_count  (count_q),
		.rd_data      (rd_entry),
		.take         (take),
		.rd_addr      (rd_addr),
		.status       (srch_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			found_q <= srch_status.result.found;
			index_q <= srch_status.result.index;
		end
	end

	assign result_valid   = result_valid_q;
	assign found          = found_q;
	assign coverage_index = index_q;

	`CIL_ASSERT_NEXT(a_lookup_busy, clk, arst_n, lookup_start, !request_ready)
	`CIL_ASSERT_NOW(a_miss_zero, clk, arst_n, result_valid && !found, coverage_index == '0)
	`CIL_ASSERT_NEXT(a_hold_kept, clk, arst_n, srch_status.hold_valid && result_valid_q && !result_ready, srch_status.hold_valid)

endmodule

[hw/rtl/cil_table_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cil_table_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/cil_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage search sequencer
// Binary search over the table RAM, one probe per cycle.
// ----------------------------------------------------------------------------
module cil_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [cil_pkg::GlyphWidth-1:0]      glyph_id,
	input  logic [cil_pkg::FormatWidth-1:0]     table_format,
	input  logic [cil_pkg::CountWidth-1:0]      entry_count,
	input  cil_pkg::entry_t                     rd_data,
	input  logic                                take,
	output logic [cil_pkg::AddrWidth-1:0]       rd_addr,
	output cil_pkg::srch_status_t               status
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_HOLD   = 3'b100
	} state_t;

	state_t state_q;

	logic [cil_pkg::CountWidth-1:0] low_q;
	logic [cil_pkg::CountWidth-1:0] high_q;
	logic [cil_pkg::AddrWidth-1:0]  mid_q;
	logic [cil_pkg::GlyphWidth-1:0] glyph_q;
	logic                           range_q;
	cil_pkg::result_t               res_q;

	logic [cil_pkg::CountWidth-1:0] high_init;
	logic [cil_pkg::AddrWidth-1:0]  mid_init;
	logic                           fmt_ok;
	logic                           hit;
	logic                           go_right;
	logic [cil_pkg::CountWidth-1:0] mid_ext;
	logic [cil_pkg::CountWidth-1:0] low_next;
	logic [cil_pkg::CountWidth-1:0] high_next;
	logic [cil_pkg::CountWidth:0]   mid_sum;
	logic [cil_pkg::AddrWidth-1:0]  mid_next;
	logic                           more;
	logic [cil_pkg::IndexWidth-1:0] hit_index;

	always_comb begin
		high_init = (entry_count > cil_pkg::CountWidth'(cil_pkg::MaxEntries)) ?
			cil_pkg::CountWidth'(cil_pkg::MaxEntries) : entry_count;
		mid_init  = high_init[cil_pkg::AddrWidth:1];
		fmt_ok    = (table_format == cil_pkg::FmtList) || (table_format == cil_pkg::FmtRange);

		if (range_q) begin
			hit      = (rd_data.first <= glyph_q) && (glyph_q <= rd_data.last);
			go_right = rd_data.last < glyph_q;
		end else begin
			hit      = rd_data.first == glyph_q;
			go_right = rd_data.first < glyph_q;
		end

		mid_ext   = {1'b0, mid_q};
		low_next  = go_right ? mid_ext + cil_pkg::CountWidth'(1) : low_q;
		high_next = go_right ? high_q : mid_ext;
		mid_sum   = {1'b0, low_next} + {1'b0, high_next};
		mid_next  = mid_sum[cil_pkg::AddrWidth:1];
		more      = low_next < high_next;

		// range hit: start index plus offset of the glyph inside the range
		hit_index = range_q ?
			{1'b0, rd_data.start} + {1'b0, glyph_q - rd_data.first} :
			cil_pkg::IndexWidth'(mid_q);

		rd_addr = (state_q == ST_SEARCH) ? mid_next : mid_init;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= (!fmt_ok || high_init == '0) ? ST_HOLD : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit || !more) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					glyph_q <= glyph_id;
					range_q <= table_format == cil_pkg::FmtRange;
					low_q   <= '0;
					high_q  <= high_init;
					mid_q   <= mid_init;
					res_q   <= '0;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					res_q <= '{found: 1'b1, index: hit_index};
				end else begin
					// narrow the window and follow the probe just issued
					low_q  <= low_next;
					high_q <= high_next;
					mid_q  <= mid_next;
					res_q  <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign status = '{
		idle:       state_q == ST_IDLE,
		hold_valid: state_q == ST_HOLD,
		result:     res_q
	};

endmodule
